// ===== src/rmts_pkg.sv =====
// Package with the shared types, codes and constants of the rate-monotonic task scheduler.
package rmts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int PID_W = 22;
  localparam int PER_W = 32;
  localparam int SHARE_W = 10;
  localparam int TIME_W = 64;
  localparam int STATUS_W = 3;
  localparam int DIVD_W = 42;
  localparam int DIVC_W = 6;
  localparam logic [SHARE_W-1:0] LIMIT_RESET = 10'd693;
  localparam logic [SHARE_W-1:0] SHARE_SCALE = 10'd1000;

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_DEREGISTER = 2'd1,
    CMD_YIELD      = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVER      = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_PAST      = 3'd4,
    ST_ZERO      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_SLEEP = 2'd0,
    MODE_READY = 2'd1,
    MODE_RUN   = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOOK,
    OP_SCAN_A,
    OP_SCAN_B,
    OP_REG,
    OP_DEREG,
    OP_YIELD,
    OP_TICK,
    OP_DISPATCH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_TICK,
    S_APPLY,
    S_SCANA,
    S_AHOLD,
    S_SCANB,
    S_DISP,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [PID_W-1:0]   pid;
    logic [PER_W-1:0]   period;
    logic [SHARE_W-1:0] share;
    logic [TIME_W-1:0]  now;
    logic [PER_W-1:0]   best_period;
  } bcast_t;

  typedef struct packed {
    logic               free_taken;
    logic               pid_taken;
    logic [SHARE_W-1:0] pid_share;
    logic               pid_rel_lt;
    logic               rdy_found;
    logic [PER_W-1:0]   rdy_period;
    logic               cr_found;
    logic [PER_W-1:0]   cr_period;
    logic [PID_W-1:0]   cr_pid;
    logic               b_taken;
    logic [PID_W-1:0]   b_pid;
  } link_t;

endpackage

// ===== src/rmts_div.sv =====
// Iterative restoring divider that computes the utilization share of a new task.
module rmts_div
  import rmts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PER_W-1:0]  runtime,
  input  logic [PER_W-1:0]  period,
  output logic              done,
  output logic [DIVD_W-1:0] quot
);

  logic [DIVD_W-1:0] q_r;
  logic [PER_W-1:0]  rem_r;
  logic [PER_W-1:0]  div_r;
  logic [DIVC_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [PER_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, q_r[DIVD_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIVC_W'(DIVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= DIVD_W'(runtime) * DIVD_W'(SHARE_SCALE);
      rem_r <= '0;
      div_r <= period;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= PER_W'(trial - {1'b0, div_r});
      end else begin
        rem_r <= trial[PER_W-1:0];
      end
      q_r <= {q_r[DIVD_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== src/rmts_cell.sv =====
// One task slot of the scheduler chain, passing lookup and selection data to its neighbor.
module rmts_cell
  import rmts_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  bcast_t bc,
  input  link_t  link_i,
  output link_t  link_o
);

  logic               valid_r;
  logic               armed_r;
  logic               cur_r;
  logic               sel_free_r;
  logic               sel_pid_r;
  logic               sel_best_r;
  logic [PID_W-1:0]   pid_r;
  logic [PER_W-1:0]   period_r;
  logic [SHARE_W-1:0] share_r;
  mode_t              mode_r;
  logic [TIME_W-1:0]  rel_r;
  link_t              link_r;
  link_t              link_nxt;
  logic               sel_free_c;
  logic               sel_pid_c;
  logic               sel_best_c;
  logic               match;
  logic               rdy;
  logic               take;
  logic               crun;
  logic               due;

  always_comb begin
    match      = valid_r && (pid_r == bc.pid);
    sel_free_c = !valid_r && !link_i.free_taken;
    sel_pid_c  = match && !link_i.pid_taken;
    rdy        = valid_r && (mode_r == MODE_READY);
    take       = rdy && (!link_i.rdy_found || (period_r < link_i.rdy_period));
    crun       = cur_r && valid_r && (mode_r == MODE_RUN);
    sel_best_c = rdy && (period_r == bc.best_period) && !link_i.b_taken;
    due        = valid_r && armed_r && (rel_r <= bc.now);

    link_nxt            = link_i;
    link_nxt.free_taken = link_i.free_taken || !valid_r;
    link_nxt.pid_taken  = link_i.pid_taken || match;
    if (sel_pid_c) begin
      link_nxt.pid_share  = share_r;
      link_nxt.pid_rel_lt = rel_r < bc.now;
    end
    link_nxt.rdy_found = link_i.rdy_found || rdy;
    if (take) begin
      link_nxt.rdy_period = period_r;
    end
    if (crun) begin
      link_nxt.cr_found  = 1'b1;
      link_nxt.cr_period = period_r;
      link_nxt.cr_pid    = pid_r;
    end
    link_nxt.b_taken = link_i.b_taken || sel_best_c;
    if (sel_best_c) begin
      link_nxt.b_pid = pid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      armed_r    <= 1'b0;
      cur_r      <= 1'b0;
      sel_free_r <= 1'b0;
      sel_pid_r  <= 1'b0;
      sel_best_r <= 1'b0;
      link_r     <= '0;
    end else begin
      link_r <= link_nxt;
      case (bc.op)
        OP_LOOK: begin
          sel_free_r <= sel_free_c;
          sel_pid_r  <= sel_pid_c;
        end
        OP_SCAN_B: begin
          sel_best_r <= sel_best_c;
        end
        OP_REG: begin
          if (sel_free_r) begin
            valid_r <= 1'b1;
            armed_r <= 1'b0;
          end
        end
        OP_DEREG: begin
          if (sel_pid_r) begin
            valid_r <= 1'b0;
            armed_r <= 1'b0;
            cur_r   <= 1'b0;
          end
        end
        OP_YIELD: begin
          if (sel_pid_r) begin
            armed_r <= 1'b1;
          end
        end
        OP_TICK: begin
          if (due) begin
            armed_r <= 1'b0;
          end
        end
        OP_DISPATCH: begin
          cur_r <= sel_best_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (bc.op)
      OP_REG: begin
        if (sel_free_r) begin
          pid_r    <= bc.pid;
          period_r <= bc.period;
          share_r  <= bc.share;
          mode_r   <= MODE_SLEEP;
          rel_r    <= bc.now + TIME_W'(bc.period);
        end
      end
      OP_YIELD: begin
        if (sel_pid_r) begin
          mode_r <= MODE_SLEEP;
        end
      end
      OP_TICK: begin
        if (due) begin
          mode_r <= MODE_READY;
          rel_r  <= bc.now + TIME_W'(period_r);
        end
      end
      OP_DISPATCH: begin
        if (sel_best_r) begin
          mode_r <= MODE_RUN;
        end else if (crun) begin
          mode_r <= MODE_READY;
        end
      end
      default: begin
      end
    endcase
  end

  assign link_o = link_r;

endmodule

// ===== src/rate_monotonic_task_scheduler.sv =====
// Top level of the rate-monotonic task scheduler: command sequencer, slot chain and divider.
// An admitted command passes lookup, check, apply and both scans; a refused one skips the apply step.
// A tick skips the lookup pass and goes through a tick step and apply before the scans.
// A register with a nonzero period waits in the check for the share divider to finish.
// One command is in work at a time; a stalled result holds the sequencer and the input.
// Synchronous reset empties the slot table, clears time and utilization, sets the limit to 693.
module rate_monotonic_task_scheduler
  import rmts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [PID_W-1:0]    in_pid,
  input  logic [PER_W-1:0]    in_period,
  input  logic [PER_W-1:0]    in_runtime,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_running_valid,
  output logic [PID_W-1:0]    out_running_pid,
  output logic [SHARE_W-1:0]  out_utilization,
  input  logic                cfg_wr_en,
  input  logic [SHARE_W-1:0]  cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_TASKS);

  state_t             state_r;
  state_t             state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  cmd_t               cmd_r;
  logic [PID_W-1:0]   pid_r;
  logic [PER_W-1:0]   period_r;
  logic [SHARE_W-1:0] limit_r;
  logic [SHARE_W-1:0] util_r;
  logic [TIME_W-1:0]  now_r;
  status_t            st_r;
  status_t            chk_status;
  logic               chk_wait;
  link_t              a_r;
  logic               res_rv_r;
  logic [PID_W-1:0]   res_pid_r;
  logic               out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic               out_rv_r;
  logic [PID_W-1:0]   out_pid_r;
  logic [SHARE_W-1:0] out_util_r;
  logic               accept;
  logic               cnt_end;
  logic               disp;
  logic               out_free;
  logic               div_done;
  logic [DIVD_W-1:0]  quot;
  logic [DIVD_W:0]    total;
  bcast_t             bc;
  link_t              links [MAX_TASKS+1];

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign cnt_end  = cnt_r == CNT_W'(MAX_TASKS - 1);
  assign out_free = !out_valid_r || !out_stall;
  assign total    = (DIVD_W+1)'(util_r) + (DIVD_W+1)'(quot);
  assign disp     = a_r.rdy_found && !(a_r.cr_found && (a_r.cr_period < a_r.rdy_period));

  rmts_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && (cmd_t'(in_command) == CMD_REGISTER)),
    .runtime (in_runtime),
    .period  (in_period),
    .done    (div_done),
    .quot    (quot)
  );

  assign links[0] = '0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    rmts_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .bc     (bc),
      .link_i (links[i]),
      .link_o (links[i+1])
    );
  end

  always_comb begin
    chk_wait   = 1'b0;
    chk_status = ST_OK;
    case (cmd_r)
      CMD_REGISTER: begin
        if (period_r == '0) begin
          chk_status = ST_ZERO;
        end else if (!div_done) begin
          chk_wait = 1'b1;
        end else if (total > (DIVD_W+1)'(limit_r)) begin
          chk_status = ST_OVER;
        end else if (!links[MAX_TASKS].free_taken) begin
          chk_status = ST_FULL;
        end
      end
      CMD_DEREGISTER: begin
        if (!links[MAX_TASKS].pid_taken) begin
          chk_status = ST_NOT_FOUND;
        end
      end
      CMD_YIELD: begin
        if (!links[MAX_TASKS].pid_taken) begin
          chk_status = ST_NOT_FOUND;
        end else if (links[MAX_TASKS].pid_rel_lt) begin
          chk_status = ST_PAST;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (cmd_t'(in_command) == CMD_TICK) ? S_TICK : S_LOOK;
        end
      end
      S_LOOK: begin
        if (cnt_end) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!chk_wait) begin
          state_nxt = (chk_status == ST_OK) ? S_APPLY : S_SCANA;
        end
      end
      S_TICK:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_SCANA;
      S_SCANA: begin
        if (cnt_end) begin
          state_nxt = S_AHOLD;
        end
      end
      S_AHOLD: state_nxt = S_SCANB;
      S_SCANB: begin
        if (cnt_end) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    bc.op          = OP_IDLE;
    bc.pid         = pid_r;
    bc.period      = period_r;
    bc.share       = quot[SHARE_W-1:0];
    bc.now         = now_r;
    bc.best_period = a_r.rdy_period;
    case (state_r)
      S_LOOK:  bc.op = OP_LOOK;
      S_APPLY: begin
        case (cmd_r)
          CMD_REGISTER:   bc.op = OP_REG;
          CMD_DEREGISTER: bc.op = OP_DEREG;
          CMD_YIELD:      bc.op = OP_YIELD;
          CMD_TICK:       bc.op = OP_TICK;
          default:        bc.op = OP_IDLE;
        endcase
      end
      S_SCANA: bc.op = OP_SCAN_A;
      S_AHOLD: bc.op = OP_SCAN_A;
      S_SCANB: bc.op = OP_SCAN_B;
      S_DISP:  bc.op = disp ? OP_DISPATCH : OP_IDLE;
      default: bc.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      limit_r     <= LIMIT_RESET;
      util_r      <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == S_TICK) begin
        now_r <= now_r + 1'b1;
      end
      if (state_r == S_APPLY) begin
        if (cmd_r == CMD_REGISTER) begin
          util_r <= total[SHARE_W-1:0];
        end else if (cmd_r == CMD_DEREGISTER) begin
          util_r <= (util_r >= links[MAX_TASKS].pid_share) ?
                    util_r - links[MAX_TASKS].pid_share : '0;
        end
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd_t'(in_command);
      pid_r    <= in_pid;
      period_r <= in_period;
      st_r     <= ST_OK;
    end
    if ((state_r == S_CHECK) && !chk_wait) begin
      st_r <= chk_status;
    end
    if (state_r == S_AHOLD) begin
      a_r <= links[MAX_TASKS];
    end
    if (state_r == S_DISP) begin
      res_rv_r  <= disp || a_r.cr_found;
      res_pid_r <= disp ? links[MAX_TASKS].b_pid : (a_r.cr_found ? a_r.cr_pid : '0);
    end
    if ((state_r == S_DONE) && out_free) begin
      out_status_r <= st_r;
      out_rv_r     <= res_rv_r;
      out_pid_r    <= res_pid_r;
      out_util_r   <= util_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_running_valid = out_rv_r;
  assign out_running_pid   = out_pid_r;
  assign out_utilization   = out_util_r;

endmodule

// ===== src/rmts_chk.sv =====
// Port-level assertion checker for the rate-monotonic task scheduler and its bind.
module rmts_chk
  import rmts_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_running_valid,
  input logic [PID_W-1:0]    out_running_pid,
  input logic [SHARE_W-1:0]  out_utilization
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while a command is in work");

  a_pid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running_valid |-> out_running_pid == '0)
    else $error("running pid is not zero with no running task");

  a_util_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_utilization <= SHARE_SCALE)
    else $error("utilization above full scale");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_ZERO)
    else $error("status code out of range");

endmodule

bind rate_monotonic_task_scheduler rmts_chk u_rmts_chk (.*);
